[hw/rtl/kqt_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the keyed quantity table.
`timescale 1ns / 1ps
`default_nettype none

package kqt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int QTY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_UPDATE = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RES_ERROR    = 2'd0,
    RES_INSERT   = 2'd1,
    RES_QUANTITY = 2'd2
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     scan;
    logic     qty_read;
    logic     load;
    res_sel_t res_sel;
    status_t  err_status;
  } kqt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;
    logic hit;
    logic miss;
    logic out_free;
  } kqt_stat_t;

endpackage

`default_nettype wire

[hw/rtl/keyed_quantity_table_top.sv]
// Top level of the keyed quantity table: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  op, key, amount
// result    out        out_valid/out_stall  status, quantity, slot
//
// With N entries stored, a request is decoded, then up to N stored keys are scanned at
// one key per cycle, and on a hit a search or update reads the quantity before the reply.
// The next request can be taken in the cycle after the result is loaded.
// Reset is synchronous on rst and clears the entry count; memory contents are never reset.
// While a result is stalled, the next request is still taken and worked on; its result
// waits for the register to free up. in_stall stays high from each transfer to its reply.

module keyed_quantity_table_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [kqt_pkg::OP_W-1:0]     op,
  input  wire logic signed [kqt_pkg::KEY_W-1:0]    key,
  input  wire logic signed [kqt_pkg::QTY_W-1:0]    amount,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [kqt_pkg::STATUS_W-1:0] status,
  output logic signed      [kqt_pkg::QTY_W-1:0]    quantity,
  output logic             [kqt_pkg::SLOT_W-1:0]   slot
);

  kqt_pkg::kqt_cmd_t  cmd;
  kqt_pkg::kqt_stat_t stat;

  // The controller sequences decode, the key scan, the quantity read and the reply.
  kqt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the request, both memories, the entry count and the result register.
  kqt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .key       (key),
    .amount    (amount),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .quantity  (quantity),
    .slot      (slot)
  );

`ifndef SYNTH
  // A result never appears in the cycle right after a request transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !cmd.load)
    else $error("result loaded directly after request transfer");

  // A result is loaded only when the output register is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending result");

  // A loaded result is offered on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not offered");

  // No request is taken while a result load is under way.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> in_stall)
    else $error("request taken while replying");
`endif

endmodule

`default_nettype wire

[hw/rtl/kqt_datapath.sv]
// Datapath of the keyed quantity table: request registers, key and quantity memories, scan and result.
`timescale 1ns / 1ps
`default_nettype none

module kqt_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic        [kqt_pkg::OP_W-1:0]    op,
  input  wire logic signed [kqt_pkg::KEY_W-1:0]   key,
  input  wire logic signed [kqt_pkg::QTY_W-1:0]   amount,
  input  wire kqt_pkg::kqt_cmd_t                  cmd,
  output kqt_pkg::kqt_stat_t                      stat,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic             [kqt_pkg::STATUS_W-1:0] status,
  output logic signed      [kqt_pkg::QTY_W-1:0]   quantity,
  output logic             [kqt_pkg::SLOT_W-1:0]  slot
);

  kqt_pkg::op_t                     op_r;
  logic [kqt_pkg::KEY_W-1:0]        key_r;
  logic [kqt_pkg::QTY_W-1:0]        amount_r;
  logic [kqt_pkg::COUNT_W-1:0]      count;
  logic [kqt_pkg::COUNT_W-1:0]      idx;
  logic                             pend;
  logic [kqt_pkg::ADDR_W-1:0]       pend_idx;
  logic [kqt_pkg::KEY_W-1:0]        key_rd;
  logic [kqt_pkg::ADDR_W-1:0]       slot_idx;
  logic [kqt_pkg::QTY_W-1:0]        qty_rd;
  logic [kqt_pkg::STATUS_W-1:0]     status_r;
  logic [kqt_pkg::QTY_W-1:0]        quantity_r;
  logic [kqt_pkg::SLOT_W-1:0]       slot_r;
  logic                             out_valid_r;

  logic [kqt_pkg::KEY_W-1:0]        key_mem [kqt_pkg::TABLE_DEPTH];
  logic [kqt_pkg::QTY_W-1:0]        qty_mem [kqt_pkg::TABLE_DEPTH];

  logic                             in_range;
  logic                             issue;
  logic                             hit;
  logic                             insert_load;
  logic                             qty_load;
  logic [kqt_pkg::QTY_W-1:0]        qty_sum;
  logic                             qty_we;
  logic [kqt_pkg::ADDR_W-1:0]       qty_waddr;
  logic [kqt_pkg::QTY_W-1:0]        qty_wdata;
  logic [kqt_pkg::SLOT_W+kqt_pkg::ADDR_W-1:0] count_slot_wide;
  logic [kqt_pkg::SLOT_W+kqt_pkg::ADDR_W-1:0] hit_slot_wide;

  assign in_range    = idx < count;
  assign issue       = cmd.scan && in_range;
  assign hit         = pend && (key_rd == key_r);
  assign insert_load = cmd.load && (cmd.res_sel == kqt_pkg::RES_INSERT);
  assign qty_load    = cmd.load && (cmd.res_sel == kqt_pkg::RES_QUANTITY);
  assign qty_sum     = qty_rd + ((op_r == kqt_pkg::OP_UPDATE) ? amount_r : '0);

  assign count_slot_wide = {{kqt_pkg::SLOT_W{1'b0}}, count[kqt_pkg::ADDR_W-1:0]};
  assign hit_slot_wide   = {{kqt_pkg::SLOT_W{1'b0}}, slot_idx};

  always_comb begin
    qty_we    = 1'b0;
    qty_waddr = slot_idx;
    qty_wdata = qty_sum;
    if (insert_load) begin
      qty_we    = 1'b1;
      qty_waddr = count[kqt_pkg::ADDR_W-1:0];
      qty_wdata = amount_r;
    end else if (qty_load && (op_r == kqt_pkg::OP_UPDATE)) begin
      qty_we = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      idx         <= '0;
      pend        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end
      if (insert_load) begin
        count <= count + 1'b1;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, scan and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= kqt_pkg::op_t'(op);
      key_r    <= key;
      amount_r <= amount;
    end
    if (cmd.scan) begin
      pend_idx <= idx[kqt_pkg::ADDR_W-1:0];
      if (hit) begin
        slot_idx <= pend_idx;
      end
    end
    if (cmd.load) begin
      case (cmd.res_sel)
        kqt_pkg::RES_INSERT: begin
          status_r   <= kqt_pkg::ST_OK;
          quantity_r <= amount_r;
          slot_r     <= count_slot_wide[kqt_pkg::SLOT_W-1:0];
        end
        kqt_pkg::RES_QUANTITY: begin
          status_r   <= kqt_pkg::ST_OK;
          quantity_r <= qty_sum;
          slot_r     <= hit_slot_wide[kqt_pkg::SLOT_W-1:0];
        end
        default: begin
          status_r   <= cmd.err_status;
          quantity_r <= '0;
          slot_r     <= '0;
        end
      endcase
    end
  end

  // Key memory: one read port for the scan, one write port for inserts.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      key_rd <= key_mem[idx[kqt_pkg::ADDR_W-1:0]];
    end
    if (insert_load) begin
      key_mem[count[kqt_pkg::ADDR_W-1:0]] <= key_r;
    end
  end

  // Quantity memory: one read port, one write port.
  always_ff @(posedge clk) begin
    if (cmd.qty_read) begin
      qty_rd <= qty_mem[slot_idx];
    end
    if (qty_we) begin
      qty_mem[qty_waddr] <= qty_wdata;
    end
  end

  assign stat.op       = op_r;
  assign stat.full     = count == kqt_pkg::COUNT_W'(kqt_pkg::TABLE_DEPTH);
  assign stat.hit      = hit;
  assign stat.miss     = !pend && !in_range;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign status    = status_r;
  assign quantity  = quantity_r;
  assign slot      = slot_r;

endmodule

`default_nettype wire

[hw/rtl/kqt_ctrl.sv]
// Controller state machine of the keyed quantity table.
`timescale 1ns / 1ps
`default_nettype none

module kqt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire kqt_pkg::kqt_stat_t stat,
  output kqt_pkg::kqt_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_QREAD,
    S_QDONE,
    S_INSERT,
    S_REPLY
  } state_t;

  state_t            state;
  kqt_pkg::status_t  err_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      err_status <= kqt_pkg::ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (stat.op == kqt_pkg::OP_UNUSED) begin
            err_status <= kqt_pkg::ST_MISSING;
            state      <= S_REPLY;
          end else if ((stat.op == kqt_pkg::OP_INSERT) && stat.full) begin
            err_status <= kqt_pkg::ST_FULL;
            state      <= S_REPLY;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.hit) begin
            if (stat.op == kqt_pkg::OP_INSERT) begin
              err_status <= kqt_pkg::ST_DUP;
              state      <= S_REPLY;
            end else begin
              state <= S_QREAD;
            end
          end else if (stat.miss) begin
            if (stat.op == kqt_pkg::OP_INSERT) begin
              state <= S_INSERT;
            end else begin
              err_status <= kqt_pkg::ST_MISSING;
              state      <= S_REPLY;
            end
          end
        end
        S_QREAD: begin
          state <= S_QDONE;
        end
        S_QDONE, S_INSERT, S_REPLY: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.capture    = (state == S_IDLE) && in_valid && !rst;
    cmd.scan       = state == S_SCAN;
    cmd.qty_read   = state == S_QREAD;
    cmd.load       = 1'b0;
    cmd.res_sel    = kqt_pkg::RES_ERROR;
    cmd.err_status = err_status;
    case (state)
      S_QDONE: begin
        cmd.load    = stat.out_free;
        cmd.res_sel = kqt_pkg::RES_QUANTITY;
      end
      S_INSERT: begin
        cmd.load    = stat.out_free;
        cmd.res_sel = kqt_pkg::RES_INSERT;
      end
      S_REPLY: begin
        cmd.load = stat.out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  assign in_stall = rst || (state != S_IDLE);

endmodule

`default_nettype wire
